FILE: hw/rtl/emls_pkg.sv
// ----------------------------------------------------------------------------
// emls_pkg: shared types and constants of the midpoint line stepper
// Holds coordinate and decision widths, the zone and item-kind codes, and the
// command that the front end hands to the stepper through the queue.
// ----------------------------------------------------------------------------
package emls_pkg;

	localparam int COORD_W    = 11;
	// coordinate difference needs one more bit
	localparam int DIFF_W     = COORD_W + 1;
	// decision value and increments reach up to four times the difference
	localparam int DEC_W      = COORD_W + 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_STEP  = 1'b1
	} kind_t;

	// zone by direction: major axis first, then minor axis
	typedef enum logic [2:0] {
		ZONE_ENE = 3'd0,
		ZONE_NNE = 3'd1,
		ZONE_NNW = 3'd2,
		ZONE_WNW = 3'd3,
		ZONE_WSW = 3'd4,
		ZONE_SSW = 3'd5,
		ZONE_SSE = 3'd6,
		ZONE_ESE = 3'd7
	} zone_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] stop_x;
		logic signed [COORD_W-1:0] stop_y;
		zone_t                     zone;
		logic signed [DEC_W-1:0]   decision;
		logic signed [DEC_W-1:0]   inc_major;
		logic signed [DEC_W-1:0]   inc_diag;
		logic                      last;
	} line_cmd_t;

endpackage

FILE: hw/rtl/emls_in_if.sv
// ----------------------------------------------------------------------------
// emls_in_if: request channel of the line stepper
// Valid/ready channel carrying a start request with endpoints or a step request.
// ----------------------------------------------------------------------------
interface emls_in_if;
	import emls_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [COORD_W-1:0] x_start;
	logic signed [COORD_W-1:0] y_start;
	logic signed [COORD_W-1:0] x_end;
	logic signed [COORD_W-1:0] y_end;

	modport source (
		output valid, kind, x_start, y_start, x_end, y_end,
		input  ready
	);

	modport sink (
		input  valid, kind, x_start, y_start, x_end, y_end,
		output ready
	);

endinterface

FILE: hw/rtl/emls_out_if.sv
// ----------------------------------------------------------------------------
// emls_out_if: pixel channel of the line stepper
// Valid/ready channel carrying one pixel, its zone and the end-of-line flag.
// ----------------------------------------------------------------------------
interface emls_out_if;
	import emls_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pixel_x;
	logic signed [COORD_W-1:0] pixel_y;
	logic [2:0]                zone;
	logic                      last;

	modport source (
		output valid, pixel_x, pixel_y, zone, last,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, zone, last,
		output ready
	);

endinterface

FILE: hw/rtl/eight_zone_midpoint_line_stepper.sv
// ----------------------------------------------------------------------------
// eight_zone_midpoint_line_stepper: midpoint line pixel generator
// Sorts a line into one of eight zones and walks it one pixel per step.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries requests. kind 0 starts a line from (x_start, y_start) to
//   (x_end, y_end) and yields the start pixel; kind 1 asks for the next pixel
//   and yields nothing once the line has ended. A start abandons any line
//   still running. pix carries one pixel per result with its zone and a
//   last flag on the end point; a zero-length line gives one pixel, last.
//   A pixel is valid once its request has passed the classification register,
//   the queue and the pixel register.
//   Throughput: one request per cycle while pix does not stall, set by the
//   single add and compare of the stepper and the combinational classification.
//   A four-entry queue sits between classification and stepping; when pix
//   stalls the queue fills and cmd.ready drops after the queue and the
//   classification register are full. A pixel is held until taken.
//   Reset clears the queue and leaves the stepper idle with no pixel pending.
// ----------------------------------------------------------------------------
module eight_zone_midpoint_line_stepper (
	input  logic       clk,
	input  logic       arst_n,
	emls_in_if.sink    cmd,
	emls_out_if.source pix
);
	import emls_pkg::*;

	logic      push;
	line_cmd_t push_data;
	logic      full;
	logic      pop;
	line_cmd_t head;
	logic      empty;

	emls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	emls_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.full    (full),
		.pop     (pop),
		.rd_data (head),
		.empty   (empty)
	);

	emls_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.pix    (pix)
	);

endmodule

FILE: hw/rtl/emls_front.sv
// ----------------------------------------------------------------------------
// emls_front: request intake and line classification
// Registers each request with its endpoint differences, then sorts a start
// request into its zone and works out the starting decision value and the
// two increments before pushing the command into the queue.
// ----------------------------------------------------------------------------
module emls_front (
	input  logic                clk,
	input  logic                arst_n,
	emls_in_if.sink             cmd,
	output logic                push,
	output emls_pkg::line_cmd_t push_data,
	input  logic                full
);
	import emls_pkg::*;

	logic                      v_s1;
	kind_t                     kind_s1;
	logic signed [COORD_W-1:0] x0_s1;
	logic signed [COORD_W-1:0] y0_s1;
	logic signed [COORD_W-1:0] x1_s1;
	logic signed [COORD_W-1:0] y1_s1;
	logic signed [DIFF_W-1:0]  dx_s1;
	logic signed [DIFF_W-1:0]  dy_s1;

	logic                      accept;
	logic [DIFF_W-1:0]         ax;
	logic [DIFF_W-1:0]         ay;
	logic                      x_major;
	logic signed [DEC_W-1:0]   ex;
	logic signed [DEC_W-1:0]   ey;
	zone_t                     zone;
	logic signed [DEC_W-1:0]   dec;
	logic signed [DEC_W-1:0]   inc_major;
	logic signed [DEC_W-1:0]   inc_diag;

	assign accept    = cmd.valid && cmd.ready;
	assign push      = v_s1 && !full;
	assign cmd.ready = !v_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_t'(cmd.kind);
			x0_s1   <= cmd.x_start;
			y0_s1   <= cmd.y_start;
			x1_s1   <= cmd.x_end;
			y1_s1   <= cmd.y_end;
			dx_s1   <= DIFF_W'(cmd.x_end) - DIFF_W'(cmd.x_start);
			dy_s1   <= DIFF_W'(cmd.y_end) - DIFF_W'(cmd.y_start);
		end
	end

	always_comb begin
		ax      = dx_s1[DIFF_W-1] ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
		ay      = dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);
		x_major = (ax >= ay);
		ex      = DEC_W'(dx_s1);
		ey      = DEC_W'(dy_s1);

		unique case ({dy_s1[DIFF_W-1], dx_s1[DIFF_W-1]})
			2'b00:   zone = x_major ? ZONE_ENE : ZONE_NNE;
			2'b01:   zone = x_major ? ZONE_WNW : ZONE_NNW;
			2'b11:   zone = x_major ? ZONE_WSW : ZONE_SSW;
			default: zone = x_major ? ZONE_ESE : ZONE_SSE;
		endcase

		unique case (zone)
			ZONE_ENE: begin
				dec       = (ey <<< 1) - ex;
				inc_major = ey <<< 1;
				inc_diag  = (ey - ex) <<< 1;
			end
			ZONE_NNE: begin
				dec       = ey - (ex <<< 1);
				inc_major = -(ex <<< 1);
				inc_diag  = (ey - ex) <<< 1;
			end
			ZONE_NNW: begin
				dec       = -ey - (ex <<< 1);
				inc_major = -(ex <<< 1);
				inc_diag  = -((ey + ex) <<< 1);
			end
			ZONE_WNW: begin
				dec       = -(ey <<< 1) - ex;
				inc_major = -(ey <<< 1);
				inc_diag  = -((ey + ex) <<< 1);
			end
			ZONE_WSW: begin
				dec       = ex - (ey <<< 1);
				inc_major = -(ey <<< 1);
				inc_diag  = (ex - ey) <<< 1;
			end
			ZONE_SSW: begin
				dec       = (ex <<< 1) - ey;
				inc_major = ex <<< 1;
				inc_diag  = (ex - ey) <<< 1;
			end
			ZONE_SSE: begin
				dec       = ey + (ex <<< 1);
				inc_major = ex <<< 1;
				inc_diag  = (ey + ex) <<< 1;
			end
			default: begin
				dec       = (ey <<< 1) + ex;
				inc_major = ey <<< 1;
				inc_diag  = (ey + ex) <<< 1;
			end
		endcase

		push_data.kind      = kind_s1;
		push_data.x         = x0_s1;
		push_data.y         = y0_s1;
		push_data.stop_x    = x1_s1;
		push_data.stop_y    = y1_s1;
		push_data.zone      = zone;
		push_data.decision  = dec;
		push_data.inc_major = inc_major;
		push_data.inc_diag  = inc_diag;
		push_data.last      = (dx_s1 == '0) && (dy_s1 == '0);
	end

	// a held request stays put until the queue takes it
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && full |=> v_s1 && $stable(dx_s1) && $stable(kind_s1))
		else $error("front: held request lost or changed");

	a_zero_zone: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_data.last |-> push_data.zone == ZONE_ENE)
		else $error("front: zero-length line not in first zone");

	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> v_s1)
		else $error("front: push without request");

endmodule

FILE: hw/rtl/emls_fifo.sv
// ----------------------------------------------------------------------------
// emls_fifo: command queue between classification and stepping
// Small first-in first-out buffer of line commands; lets the front end and the
// stepper stall independently.
// ----------------------------------------------------------------------------
module emls_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  emls_pkg::line_cmd_t wr_data,
	output logic                full,
	input  logic                pop,
	output emls_pkg::line_cmd_t rd_data,
	output logic                empty
);
	import emls_pkg::*;

	line_cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   cnt_q;

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("fifo: push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("fifo: pop while empty");

	// pointer distance wraps at the depth, so compare the low count bits
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH) &&
		(cnt_q[FIFO_PTR_W-1:0] == wr_ptr_q - rd_ptr_q))
		else $error("fifo: count and pointers disagree");

endmodule

FILE: hw/rtl/emls_back.sv
// ----------------------------------------------------------------------------
// emls_back: midpoint stepper and pixel output register
// Holds the running line, takes one command from the queue per cycle unless a
// pixel is held, and moves one pixel along the major axis per step request.
// ----------------------------------------------------------------------------
module emls_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  emls_pkg::line_cmd_t head,
	output logic                pop,
	emls_out_if.source          pix
);
	import emls_pkg::*;

	localparam logic signed [COORD_W-1:0] C_ONE = COORD_W'(1);

	logic                      busy_q;
	logic                      out_v_q;
	logic signed [COORD_W-1:0] cur_x_q;
	logic signed [COORD_W-1:0] cur_y_q;
	logic signed [COORD_W-1:0] stop_x_q;
	logic signed [COORD_W-1:0] stop_y_q;
	logic signed [DEC_W-1:0]   dec_q;
	logic signed [DEC_W-1:0]   inc_major_q;
	logic signed [DEC_W-1:0]   inc_diag_q;
	zone_t                     zone_q;
	logic signed [COORD_W-1:0] pixel_x_q;
	logic signed [COORD_W-1:0] pixel_y_q;
	zone_t                     pixel_zone_q;
	logic                      pixel_last_q;

	logic                      is_start;
	logic                      emit;
	logic                      dec_neg;
	logic                      dec_pos;
	logic                      diag;
	logic                      major_x;
	logic                      x_neg;
	logic                      y_neg;
	logic signed [COORD_W-1:0] nx;
	logic signed [COORD_W-1:0] ny;
	logic signed [DEC_W-1:0]   nd;
	logic                      step_last;

	assign is_start = (head.kind == KIND_START);
	assign pop      = !empty && (!out_v_q || pix.ready);
	// a step on an idle stepper is consumed without a pixel
	assign emit     = pop && (is_start || busy_q);

	always_comb begin
		dec_neg = dec_q[DEC_W-1];
		dec_pos = !dec_q[DEC_W-1] && (dec_q != '0);

		unique case (zone_q)
			ZONE_ENE: begin diag = !dec_neg; major_x = 1'b1; x_neg = 1'b0; y_neg = 1'b0; end
			ZONE_NNE: begin diag = dec_neg;  major_x = 1'b0; x_neg = 1'b0; y_neg = 1'b0; end
			ZONE_NNW: begin diag = dec_pos;  major_x = 1'b0; x_neg = 1'b1; y_neg = 1'b0; end
			ZONE_WNW: begin diag = dec_neg;  major_x = 1'b1; x_neg = 1'b1; y_neg = 1'b0; end
			ZONE_WSW: begin diag = !dec_neg; major_x = 1'b1; x_neg = 1'b1; y_neg = 1'b1; end
			ZONE_SSW: begin diag = !dec_pos; major_x = 1'b0; x_neg = 1'b1; y_neg = 1'b1; end
			ZONE_SSE: begin diag = !dec_neg; major_x = 1'b0; x_neg = 1'b0; y_neg = 1'b1; end
			default:  begin diag = !dec_pos; major_x = 1'b1; x_neg = 1'b0; y_neg = 1'b1; end
		endcase

		// the major axis always advances, the minor one only on a diagonal move
		if (major_x || diag) begin
			nx = x_neg ? cur_x_q - C_ONE : cur_x_q + C_ONE;
		end else begin
			nx = cur_x_q;
		end
		if (!major_x || diag) begin
			ny = y_neg ? cur_y_q - C_ONE : cur_y_q + C_ONE;
		end else begin
			ny = cur_y_q;
		end

		nd        = dec_q + (diag ? inc_diag_q : inc_major_q);
		step_last = major_x ? (nx == stop_x_q) : (ny == stop_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop && is_start) begin
				busy_q <= !head.last;
			end else if (pop && busy_q && step_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (pix.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_start) begin
			cur_x_q      <= head.x;
			cur_y_q      <= head.y;
			stop_x_q     <= head.stop_x;
			stop_y_q     <= head.stop_y;
			dec_q        <= head.decision;
			inc_major_q  <= head.inc_major;
			inc_diag_q   <= head.inc_diag;
			zone_q       <= head.zone;
			pixel_x_q    <= head.x;
			pixel_y_q    <= head.y;
			pixel_zone_q <= head.zone;
			pixel_last_q <= head.last;
		end else if (pop && busy_q) begin
			cur_x_q      <= nx;
			cur_y_q      <= ny;
			dec_q        <= nd;
			pixel_x_q    <= nx;
			pixel_y_q    <= ny;
			pixel_zone_q <= zone_q;
			pixel_last_q <= step_last;
		end
	end

	assign pix.valid   = out_v_q;
	assign pix.pixel_x = pixel_x_q;
	assign pix.pixel_y = pixel_y_q;
	assign pix.zone    = pixel_zone_q;
	assign pix.last    = pixel_last_q;

	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !is_start && busy_q && step_last |=> !busy_q && out_v_q && pix.last)
		else $error("back: final pixel did not end the line");

	a_idle_step_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !is_start && !busy_q |=> !out_v_q)
		else $error("back: idle step produced a pixel");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		pop && is_start && head.last |=> !busy_q && pix.last)
		else $error("back: zero-length line left stepper busy");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !out_v_q || pix.ready)
		else $error("back: pixel register overwritten while held");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the eight-zone midpoint line stepper
// Sends start and step requests on the cmd channel and predicts every pixel
// with its own midpoint walker. Each pixel taken from the pix channel is
// checked field by field against the oldest predicted one. Both channels idle
// in random bursts, and one long hold-off on pix makes the block stall cmd.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import emls_pkg::*;

	localparam int COORD_LO = -(1 << (COORD_W - 1));
	localparam int COORD_HI = (1 << (COORD_W - 1)) - 1;

	typedef struct {
		kind_t                     kind;
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
	} req_t;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		zone_t                     zone;
		logic                      last;
	} pixel_t;

	logic clk;
	logic arst_n;

	emls_in_if  cmd_if ();
	emls_out_if pix_if ();

	eight_zone_midpoint_line_stepper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.pix    (pix_if)
	);

	// walker state of the line being drawn
	logic signed [COORD_W-1:0] walk_x, walk_y, goal_x, goal_y;
	int                        mid_d, step_straight, step_diag;
	zone_t                     cur_zone;
	bit                        walking;

	pixel_t pixels_due[$];
	int     fails;
	int     useful_items;
	bit     idling_on;
	int     hold_request;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic bit predict_pixel(input req_t r, output pixel_t p);
		int dx, dy, ax, ay;
		int mx, my;
		bit diag, major_x, at_end;
		p = '{default: '0, zone: ZONE_ENE};
		if (r.kind == KIND_START) begin
			walk_x = r.x0;
			walk_y = r.y0;
			goal_x = r.x1;
			goal_y = r.y1;
			dx = int'(goal_x) - int'(walk_x);
			dy = int'(goal_y) - int'(walk_y);
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			if (dx >= 0 && dy >= 0)
				cur_zone = (dx >= dy) ? ZONE_ENE : ZONE_NNE;
			else if (dx < 0 && dy >= 0)
				cur_zone = (ax >= dy) ? ZONE_WNW : ZONE_NNW;
			else if (dx < 0)
				cur_zone = (ax >= ay) ? ZONE_WSW : ZONE_SSW;
			else
				cur_zone = (dx >= ay) ? ZONE_ESE : ZONE_SSE;
			case (cur_zone)
				ZONE_ENE: begin
					mid_d = 2*dy - dx; step_straight = 2*dy; step_diag = 2*(dy - dx);
				end
				ZONE_NNE: begin
					mid_d = dy - 2*dx; step_straight = -2*dx; step_diag = 2*(dy - dx);
				end
				ZONE_NNW: begin
					mid_d = -dy - 2*dx; step_straight = -2*dx; step_diag = -2*(dy + dx);
				end
				ZONE_WNW: begin
					mid_d = -2*dy - dx; step_straight = -2*dy; step_diag = -2*(dy + dx);
				end
				ZONE_WSW: begin
					mid_d = dx - 2*dy; step_straight = -2*dy; step_diag = 2*(dx - dy);
				end
				ZONE_SSW: begin
					mid_d = 2*dx - dy; step_straight = 2*dx; step_diag = 2*(dx - dy);
				end
				ZONE_SSE: begin
					mid_d = dy + 2*dx; step_straight = 2*dx; step_diag = 2*(dy + dx);
				end
				default: begin
					mid_d = 2*dy + dx; step_straight = 2*dy; step_diag = 2*(dy + dx);
				end
			endcase
			at_end = (dx == 0 && dy == 0);
			walking = !at_end;
			p = '{walk_x, walk_y, cur_zone, at_end};
			return 1'b1;
		end
		// step on an idle block: nothing comes out
		if (!walking)
			return 1'b0;
		case (cur_zone)
			ZONE_ENE, ZONE_WSW, ZONE_SSE: diag = (mid_d >= 0);
			ZONE_NNE, ZONE_WNW:           diag = (mid_d < 0);
			ZONE_NNW:                     diag = (mid_d > 0);
			default:                      diag = (mid_d <= 0);
		endcase
		// diagonal direction of the zone; the straight move takes its major part
		mx = (cur_zone inside {ZONE_NNW, ZONE_WNW, ZONE_WSW, ZONE_SSW}) ? -1 : 1;
		my = (cur_zone inside {ZONE_ENE, ZONE_NNE, ZONE_NNW, ZONE_WNW}) ? 1 : -1;
		major_x = (cur_zone inside {ZONE_ENE, ZONE_WNW, ZONE_WSW, ZONE_ESE});
		if (diag) begin
			walk_x = walk_x + COORD_W'(mx);
			walk_y = walk_y + COORD_W'(my);
			mid_d = mid_d + step_diag;
		end else begin
			if (major_x)
				walk_x = walk_x + COORD_W'(mx);
			else
				walk_y = walk_y + COORD_W'(my);
			mid_d = mid_d + step_straight;
		end
		at_end = major_x ? (walk_x == goal_x) : (walk_y == goal_y);
		if (at_end)
			walking = 1'b0;
		p = '{walk_x, walk_y, cur_zone, at_end};
		return 1'b1;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, (1 << COORD_W) - 1)) + COORD_LO;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
		if (v < COORD_LO)
			v = COORD_LO;
		else if (v > COORD_HI)
			v = COORD_HI;
		return v[COORD_W-1:0];
	endfunction

	function automatic req_t start_req(input int x0, input int y0, input int x1, input int y1);
		return '{KIND_START, clamp_coord(x0), clamp_coord(y0), clamp_coord(x1), clamp_coord(y1)};
	endfunction

	// step requests carry junk coordinates, which the block must ignore
	function automatic req_t step_req();
		return '{KIND_STEP, clamp_coord(rand_coord()), clamp_coord(rand_coord()),
			clamp_coord(rand_coord()), clamp_coord(rand_coord())};
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_request(input req_t r);
		pixel_t p;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			cmd_if.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		cmd_if.valid   = 1'b1;
		cmd_if.kind    = r.kind;
		cmd_if.x_start = r.x0;
		cmd_if.y_start = r.y0;
		cmd_if.x_end   = r.x1;
		cmd_if.y_end   = r.y1;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		if (predict_pixel(r, p)) begin
			pixels_due.push_back(p);
			useful_items++;
		end
		@(negedge clk);
	endtask

	task automatic walk_line();
		while (walking)
			send_request(step_req());
	endtask

	task automatic test_extremes();
		send_request(step_req());
		send_request(start_req(COORD_LO, COORD_HI, COORD_LO, COORD_HI));
		send_request(step_req());
		send_request(start_req(COORD_LO, COORD_LO, COORD_HI, COORD_HI));
		send_request(step_req());
		send_request(step_req());
		// abandon each running line with a new start
		send_request(start_req(COORD_HI, COORD_HI, COORD_LO, COORD_LO));
		send_request(step_req());
		send_request(start_req(COORD_HI, COORD_LO, COORD_LO, COORD_HI));
		send_request(step_req());
		send_request(start_req(COORD_LO, COORD_HI, COORD_HI, COORD_LO));
		send_request(step_req());
	endtask

	task automatic test_each_zone();
		send_request(start_req(5, -7, 7, -6));
		walk_line();
		send_request(start_req(5, -7, 6, -5));
		walk_line();
		send_request(start_req(5, -7, 4, -5));
		walk_line();
		send_request(start_req(5, -7, 3, -6));
		walk_line();
		send_request(start_req(5, -7, 3, -8));
		walk_line();
		send_request(start_req(5, -7, 4, -9));
		walk_line();
		send_request(start_req(5, -7, 6, -9));
		walk_line();
		send_request(start_req(5, -7, 7, -8));
		walk_line();
	endtask

	task automatic draw_random_line();
		int x0, y0, span, ddx, ddy, pick;
		x0 = rand_coord();
		y0 = rand_coord();
		pick = $urandom_range(0, 99);
		span = (pick < 70) ? 12 : (pick < 98) ? 64 : 200;
		ddx = int'($urandom_range(0, 2 * span)) - span;
		ddy = int'($urandom_range(0, 2 * span)) - span;
		case ($urandom_range(0, 9))
			0: ddx = 0;
			1: ddy = 0;
			2: ddy = ddx;
			3: ddy = -ddx;
			default: ;
		endcase
		if ($urandom_range(0, 11) == 0) begin
			// noise: endpoints anywhere, cut short
			send_request(start_req(x0, y0, rand_coord(), rand_coord()));
			repeat ($urandom_range(0, 10))
				send_request(step_req());
			return;
		end
		send_request(start_req(x0, y0, x0 + ddx, y0 + ddy));
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(0, 5))
				if (walking)
					send_request(step_req());
		end else begin
			walk_line();
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 2))
					send_request(step_req());
		end
	endtask

	task automatic test_random_lines(input int target);
		while (useful_items < target)
			draw_random_line();
	endtask

	task automatic test_backpressure();
		send_request(start_req(-500, 3, 500, 40));
		hold_request = 120;
		repeat (60)
			send_request(step_req());
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		pix_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				pix_if.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				pix_if.ready = 1'b0;
				stall_left--;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				pix_if.ready = 1'b0;
				stall_left = $urandom_range(1, 7) - 1;
			end else begin
				pix_if.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && pix_if.valid && pix_if.ready) begin
			if (pixels_due.size() == 0) begin
				$display("%0t: unexpected pixel (%0d,%0d) zone %0d last %0b", $time,
					pix_if.pixel_x, pix_if.pixel_y, pix_if.zone, pix_if.last);
				fails++;
			end else begin
				want = pixels_due.pop_front();
				if (pix_if.pixel_x !== want.x) begin
					$display("%0t: pixel_x expected %0d got %0d", $time, want.x, pix_if.pixel_x);
					fails++;
				end
				if (pix_if.pixel_y !== want.y) begin
					$display("%0t: pixel_y expected %0d got %0d", $time, want.y, pix_if.pixel_y);
					fails++;
				end
				if (pix_if.zone !== want.zone) begin
					$display("%0t: zone expected %0d got %0d", $time, want.zone, pix_if.zone);
					fails++;
				end
				if (pix_if.last !== want.last) begin
					$display("%0t: last expected %0b got %0b", $time, want.last, pix_if.last);
					fails++;
				end
			end
		end
	end

	initial begin
		int waited;
		fails = 0;
		useful_items = 0;
		idling_on = 1'b1;
		hold_request = 0;
		walking = 1'b0;
		walk_x = '0;
		walk_y = '0;
		goal_x = '0;
		goal_y = '0;
		mid_d = 0;
		step_straight = 0;
		step_diag = 0;
		cur_zone = ZONE_ENE;
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.kind = KIND_STEP;
		cmd_if.x_start = '0;
		cmd_if.y_start = '0;
		cmd_if.x_end = '0;
		cmd_if.y_end = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		test_each_zone();
		test_random_lines(600);
		test_backpressure();
		test_random_lines(850);
		// drop all idling for the tail of the run
		idling_on = 1'b0;
		test_random_lines(1000);

		cmd_if.valid = 1'b0;
		waited = 0;
		while (pixels_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pixels_due.size() != 0) begin
			$display("%0t: %0d pixels never arrived", $time, pixels_due.size());
			fails++;
		end
		if (fails == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/emls_pkg.sv
hw/rtl/emls_in_if.sv
hw/rtl/emls_out_if.sv
hw/rtl/emls_front.sv
hw/rtl/emls_fifo.sv
hw/rtl/emls_back.sv
hw/rtl/eight_zone_midpoint_line_stepper.sv
tb/tb_top.sv
